// ===== rtl/kmsd_pkg.sv =====
// kmsd_pkg: shared types, register indexes and reset constants for the
// keypad matrix scanner with debounce. No dependencies.
package kmsd_pkg;

  localparam int ROWS_DEF    = 4;
  localparam int COLUMNS_DEF = 4;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;

  localparam logic [3:0] COUNT_MAX      = 4'hF;
  localparam logic [3:0] DEBOUNCE_RESET = 4'd10;
  localparam logic [15:0] KEYMAP_RESET [4] = '{16'hA321, 16'hB654, 16'hC987, 16'hDF0E};

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_DEBOUNCE_COUNT = 3'd0,
    REG_KEYMAP_ROW0    = 3'd1,
    REG_KEYMAP_ROW1    = 3'd2,
    REG_KEYMAP_ROW2    = 3'd3,
    REG_KEYMAP_ROW3    = 3'd4
  } reg_index_t;

  typedef struct packed {
    logic [1:0]  drive_column;
    logic        key_event;
    logic [3:0]  key_code;
    logic [15:0] held_mask;
  } result_t;

  function automatic logic [3:0] nibble(input logic [15:0] word, input logic [1:0] sel);
    return word[{sel, 2'b00} +: 4];
  endfunction

endpackage

// ===== rtl/kmsd_core.sv =====
// kmsd_core: configuration registers, per-key levels and stability counters,
// and the single-pass update for one scan beat. Depends on kmsd_pkg.
module kmsd_core #(
  parameter int ROWS    = kmsd_pkg::ROWS_DEF,
  parameter int COLUMNS = kmsd_pkg::COLUMNS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [kmsd_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [kmsd_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                             accept,
  input  logic [3:0]                       row_levels,
  output kmsd_pkg::result_t                result
);

  localparam int COL_W = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
  localparam int NKEYS = ROWS * COLUMNS;

  logic [3:0]         debounce_count;
  logic [15:0]        keymap [4];
  logic [COL_W-1:0]   scan_column;
  logic [COLUMNS-1:0] levels [ROWS];
  logic [3:0]         counts [ROWS][COLUMNS];

  logic [COLUMNS-1:0] levels_next [ROWS];
  logic [COLUMNS-1:0] col_onehot;
  logic [COL_W-1:0]   col_next;
  logic [3:0]         col_w;
  logic               col_in_map;
  logic [1:0]         kmap_sel;
  logic [ROWS-1:0]    row_bit;
  logic [ROWS-1:0]    stored;
  logic [ROWS-1:0]    match;
  logic [ROWS-1:0]    qual;
  logic [3:0]         cnt_sel [ROWS];
  logic [3:0]         cnt_inc [ROWS];
  logic [3:0]         code_row [ROWS];
  logic [NKEYS-1:0]   flat_next;
  logic               ev;
  logic [3:0]         code;

  assign col_w      = 4'(scan_column);
  assign col_in_map = (col_w < 4'd4);
  assign col_onehot = COLUMNS'(1) << scan_column;
  assign col_next   = (scan_column == COL_W'(COLUMNS - 1)) ? '0 : scan_column + COL_W'(1);
  assign kmap_sel   = 2'(cfg_index - kmsd_pkg::REG_KEYMAP_ROW0);

  for (genvar r = 0; r < ROWS; r++) begin : g_row
    if (r < 4) begin : g_mapped
      assign row_bit[r]  = row_levels[r];
      assign code_row[r] = col_in_map ? kmsd_pkg::nibble(keymap[r], col_w[1:0]) : 4'd0;
    end else begin : g_unmapped
      assign row_bit[r]  = 1'b0;
      assign code_row[r] = 4'd0;
    end
    assign cnt_sel[r] = counts[r][scan_column];
    assign cnt_inc[r] = cnt_sel[r] + 4'd1;
    assign stored[r]  = levels[r][scan_column];
    assign match[r]   = (row_bit[r] == stored[r]);
    assign qual[r]    = match[r] && (cnt_sel[r] != kmsd_pkg::COUNT_MAX) &&
                        (cnt_inc[r] == debounce_count) && !row_bit[r];
    assign levels_next[r] = match[r] ? levels[r] : (levels[r] ^ col_onehot);
    assign flat_next[r*COLUMNS +: COLUMNS] = levels_next[r];
  end

  // highest qualifying row wins
  always_comb begin
    ev   = 1'b0;
    code = 4'd0;
    for (int r = 0; r < ROWS; r++) begin
      if (qual[r]) begin
        ev   = 1'b1;
        code = code_row[r];
      end
    end
  end

  always_comb begin
    result.drive_column = 2'(col_next);
    result.key_event    = ev;
    result.key_code     = code;
    result.held_mask    = 16'(flat_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_count <= kmsd_pkg::DEBOUNCE_RESET;
      for (int i = 0; i < 4; i++) keymap[i] <= kmsd_pkg::KEYMAP_RESET[i];
      scan_column <= '0;
      for (int r = 0; r < ROWS; r++) begin
        levels[r] <= '0;
        for (int c = 0; c < COLUMNS; c++) counts[r][c] <= '0;
      end
    end else begin
      if (cfg_we) begin
        unique case (cfg_index) inside
          kmsd_pkg::REG_DEBOUNCE_COUNT: debounce_count <= cfg_data[3:0];
          kmsd_pkg::REG_KEYMAP_ROW0, kmsd_pkg::REG_KEYMAP_ROW1,
          kmsd_pkg::REG_KEYMAP_ROW2, kmsd_pkg::REG_KEYMAP_ROW3: keymap[kmap_sel] <= cfg_data;
          default: ;
        endcase
      end
      if (accept) begin
        scan_column <= col_next;
        for (int r = 0; r < ROWS; r++) begin
          levels[r] <= levels_next[r];
          if (!match[r]) begin
            counts[r][scan_column] <= 4'd0;
          end else if (cnt_sel[r] != kmsd_pkg::COUNT_MAX) begin
            counts[r][scan_column] <= cnt_inc[r];
          end
        end
      end
    end
  end

endmodule

// ===== rtl/kmsd_out_buf.sv =====
// kmsd_out_buf: two-entry result queue between the scan update and the
// output channel. Depends on kmsd_pkg for the result struct.
module kmsd_out_buf (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  kmsd_pkg::result_t push_data,
  output logic              not_full,
  output logic              out_valid,
  input  logic              out_ready,
  output kmsd_pkg::result_t pop_data
);

  kmsd_pkg::result_t slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic [1:0] count_next;
  logic       pop;

  assign not_full  = (count != 2'd2);
  assign out_valid = (count != 2'd0);
  assign pop       = out_valid && out_ready;
  assign pop_data  = slots[rd_ptr];

  always_comb begin
    case ({push, pop})
      2'b10:   count_next = count + 2'd1;
      2'b01:   count_next = count - 2'd1;
      default: count_next = count;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_data;
  end

endmodule

// ===== rtl/keypad_matrix_scan_debounce.sv =====
// keypad_matrix_scan_debounce: top level of the keypad scanner with debounce.
// Depends on kmsd_pkg, kmsd_core and kmsd_out_buf.
//
//   channel | handshake            | payload
//   in      | in_valid / in_ready  | row_levels
//   out     | out_valid / out_ready| drive_column, key_event, key_code, held_mask
//   cfg     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// One scan beat per cycle while in_ready is high; its result is registered into
// the result queue on accept. Throughput is set by the two-entry result queue:
// in_ready drops only when both entries wait on the output side.
// Synchronous reset restores the keymap and debounce count, clears all key
// levels and counters, and empties the queue. cfg_ready is always high.
module keypad_matrix_scan_debounce #(
  parameter int ROWS    = kmsd_pkg::ROWS_DEF,
  parameter int COLUMNS = kmsd_pkg::COLUMNS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [3:0]                       row_levels,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [1:0]                       drive_column,
  output logic                             key_event,
  output logic [3:0]                       key_code,
  output logic [15:0]                      held_mask,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [kmsd_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [kmsd_pkg::CFG_DATA_W-1:0]  cfg_data
);

  kmsd_pkg::result_t core_result;
  kmsd_pkg::result_t out_result;
  logic              accept;
  logic              not_full;

  assign cfg_ready = 1'b1;
  assign in_ready  = not_full;
  assign accept    = in_valid && not_full;

  kmsd_core #(
    .ROWS    (ROWS),
    .COLUMNS (COLUMNS)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .accept     (accept),
    .row_levels (row_levels),
    .result     (core_result)
  );

  kmsd_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .push_data (core_result),
    .not_full  (not_full),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .pop_data  (out_result)
  );

  assign drive_column = out_result.drive_column;
  assign key_event    = out_result.key_event;
  assign key_code     = out_result.key_code;
  assign held_mask    = out_result.held_mask;

endmodule

// ===== rtl/kmsd_checker.sv =====
// kmsd_checker: port-level assertions for the keypad scanner, bound to
// keypad_matrix_scan_debounce. No package dependency.
module kmsd_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  drive_column,
  input logic        key_event,
  input logic [3:0]  key_code,
  input logic [15:0] held_mask
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result pending right after reset");

  a_accept_result: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> out_valid)
    else $error("accepted beat produced no result");

  a_no_event_code: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !key_event) |-> (key_code == 4'd0))
    else $error("key_code nonzero without key_event");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(drive_column) &&
      $stable(key_event) && $stable(key_code) && $stable(held_mask)))
    else $error("stalled result beat changed");

endmodule

bind keypad_matrix_scan_debounce kmsd_checker u_kmsd_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .drive_column (drive_column),
  .key_event    (key_event),
  .key_code     (key_code),
  .held_mask    (held_mask)
);
